@@ hw/rtl/rlcpe_pkg.sv @@
// shared types and constants of the rgb led chain pulse encoder
`timescale 1ns / 1ps

package rlcpe_pkg;

    localparam int unsigned BITS_PER_LED = 24;
    localparam int unsigned BIT_W        = 5;

    localparam logic [7:0] RESET_DUTY_ONE  = 8'd70;
    localparam logic [7:0] RESET_DUTY_ZERO = 8'd30;
    localparam logic [7:0] RESET_TRAIL_LEN = 8'd50;

    localparam logic [BIT_W-1:0] LAST_BIT = BIT_W'(BITS_PER_LED - 1);

    typedef enum logic [1:0] {
        FN_SET   = 2'd0,
        FN_START = 2'd1,
        FN_TICK  = 2'd2
    } func_t;

    typedef enum logic [1:0] {
        CFG_DUTY_ONE  = 2'd0,
        CFG_DUTY_ZERO = 2'd1,
        CFG_TRAIL_LEN = 2'd2
    } cfg_idx_t;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_COPY,
        ST_COLOUR,
        ST_TRAIL
    } state_t;

    // snapshot copy progress reported by the colour memory
    typedef struct packed {
        logic first;
        logic done;
    } copy_stat_t;

endpackage

@@ hw/rtl/rlcpe_cmd_if.sv @@
// command channel: set colour, start frame, slot tick
`timescale 1ns / 1ps

interface rlcpe_cmd_if;
    logic       valid;
    logic       ready;
    logic [1:0] func;
    logic [7:0] led_index;
    logic [7:0] red;
    logic [7:0] green;
    logic [7:0] blue;

    modport source (output valid, output func, output led_index, output red,
                    output green, output blue, input ready);
    modport sink (input valid, input func, input led_index, input red,
                  input green, input blue, output ready);
endinterface

@@ hw/rtl/rlcpe_slot_if.sv @@
// slot result channel: duty value and frame end flag
`timescale 1ns / 1ps

interface rlcpe_slot_if;
    logic       valid;
    logic       ready;
    logic [7:0] duty;
    logic       frame_last;

    modport source (output valid, output duty, output frame_last, input ready);
    modport sink (input valid, input duty, input frame_last, output ready);
endinterface

@@ hw/rtl/rgb_led_chain_pulse_encoder.sv @@
// top level of the rgb led chain pulse encoder
//
// channel  dir  handshake      payload
// cmd      in   valid/ready    func, led_index, red, green, blue
// slot     out  valid/ready    duty, frame_last
// cfg      in   cfg_we         cfg_index, cfg_wdata
//
// a tick result leaves from an output register
// a start copies the colour store into the snapshot memory one led per cycle:
//   cmd is held off from an accepted start until the copy has written the last led
// reset marks every colour store entry unwritten, so it reads as black; registers to 70 / 30 / 50, block idle
// outside the copy, cmd is accepted while the output register is empty or being taken
`timescale 1ns / 1ps

module rgb_led_chain_pulse_encoder #(
    parameter int unsigned LED_COUNT = 8
) (
    input  logic        clk,
    input  logic        rst_n,
    rlcpe_cmd_if.sink   cmd,
    rlcpe_slot_if.source slot,
    input  logic        cfg_we,
    input  logic [1:0]  cfg_index,
    input  logic [7:0]  cfg_wdata
);
    import rlcpe_pkg::*;

    localparam int unsigned      IDX_W    = (LED_COUNT > 1) ? $clog2(LED_COUNT) : 1;
    localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(LED_COUNT - 1);
    localparam logic [8:0]       LED_LIM  = 9'(LED_COUNT);

    logic [7:0]       duty_one_reg, duty_zero_reg, trail_len_reg;
    logic [7:0]       lat_one_reg, lat_zero_reg, lat_reset_reg;
    state_t           state_reg, state_next;
    logic [IDX_W-1:0] led_reg;
    logic [BIT_W-1:0] bit_reg;
    logic [7:0]       trail_reg;
    logic [23:0]      shift_reg;
    logic             out_valid_reg;
    logic [7:0]       out_duty_reg;
    logic             out_last_reg;

    logic             accept, do_set, do_start, do_tick;
    logic             res_valid, res_last;
    logic [7:0]       res_duty;
    logic [IDX_W-1:0] snap_raddr;
    logic [23:0]      snap_rdata, copy_data;
    copy_stat_t       copy_stat;

    assign cmd.ready = (state_reg != ST_COPY) && (!out_valid_reg || slot.ready);
    assign accept    = cmd.valid && cmd.ready;
    assign do_set    = accept && (cmd.func == FN_SET) && ({1'b0, cmd.led_index} < LED_LIM);
    assign do_start  = accept && (cmd.func == FN_START) && (state_reg == ST_IDLE);
    assign do_tick   = accept && (cmd.func == FN_TICK);
    assign snap_raddr = (led_reg == LAST_IDX) ? '0 : led_reg + 1'b1;

    rlcpe_colour_mem #(
        .LED_COUNT (LED_COUNT),
        .IDX_W     (IDX_W)
    ) u_mem (
        .clk        (clk),
        .rst_n      (rst_n),
        .set_we     (do_set),
        .set_idx    (cmd.led_index[IDX_W-1:0]),
        .set_data   ({cmd.green, cmd.red, cmd.blue}),
        .copy_start (do_start),
        .snap_raddr (snap_raddr),
        .snap_rdata (snap_rdata),
        .copy_data  (copy_data),
        .copy_stat  (copy_stat)
    );

    // next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (do_start)
                begin
                    state_next = ST_COPY;
                end
            end
            ST_COPY:
            begin
                if (copy_stat.done)
                begin
                    state_next = ST_COLOUR;
                end
            end
            ST_COLOUR:
            begin
                if (do_tick && (bit_reg == LAST_BIT) && (led_reg == LAST_IDX))
                begin
                    state_next = (lat_reset_reg == 8'd0) ? ST_IDLE : ST_TRAIL;
                end
            end
            ST_TRAIL:
            begin
                if (do_tick && (trail_reg == lat_reset_reg - 8'd1))
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // slot result
    always_comb
    begin
        res_valid = 1'b0;
        res_duty  = 8'd0;
        res_last  = 1'b0;
        unique case (state_reg)
            ST_COLOUR:
            begin
                res_valid = do_tick;
                res_duty  = shift_reg[23] ? lat_one_reg : lat_zero_reg;
                res_last  = (bit_reg == LAST_BIT) && (led_reg == LAST_IDX)
                            && (lat_reset_reg == 8'd0);
            end
            ST_TRAIL:
            begin
                res_valid = do_tick;
                res_last  = (trail_reg == lat_reset_reg - 8'd1);
            end
            default:
            begin
                res_valid = 1'b0;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            duty_one_reg    <= RESET_DUTY_ONE;
            duty_zero_reg   <= RESET_DUTY_ZERO;
            trail_len_reg   <= RESET_TRAIL_LEN;
            lat_one_reg     <= 8'd0;
            lat_zero_reg    <= 8'd0;
            lat_reset_reg   <= 8'd0;
            state_reg       <= ST_IDLE;
            led_reg         <= '0;
            bit_reg         <= '0;
            trail_reg       <= 8'd0;
            out_valid_reg   <= 1'b0;
        end
        else
        begin
            if (cfg_we)
            begin
                unique case (cfg_index)
                    CFG_DUTY_ONE:    duty_one_reg    <= cfg_wdata;
                    CFG_DUTY_ZERO:   duty_zero_reg   <= cfg_wdata;
                    CFG_TRAIL_LEN:   trail_len_reg   <= cfg_wdata;
                    default:         duty_one_reg    <= duty_one_reg;
                endcase
            end
            state_reg <= state_next;
            if (do_start)
            begin
                lat_one_reg   <= duty_one_reg;
                lat_zero_reg  <= duty_zero_reg;
                lat_reset_reg <= trail_len_reg;
                led_reg       <= '0;
                bit_reg       <= '0;
                trail_reg     <= 8'd0;
            end
            else if (do_tick && (state_reg == ST_COLOUR))
            begin
                if (bit_reg == LAST_BIT)
                begin
                    bit_reg <= '0;
                    if (led_reg != LAST_IDX)
                    begin
                        led_reg <= led_reg + 1'b1;
                    end
                end
                else
                begin
                    bit_reg <= bit_reg + 1'b1;
                end
            end
            else if (do_tick && (state_reg == ST_TRAIL))
            begin
                trail_reg <= trail_reg + 8'd1;
            end
            if (res_valid)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (slot.ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // led bit shifter and output payload
    always_ff @(posedge clk)
    begin
        if (copy_stat.first)
        begin
            shift_reg <= copy_data;
        end
        else if (do_tick && (state_reg == ST_COLOUR))
        begin
            if (bit_reg == LAST_BIT)
            begin
                shift_reg <= snap_rdata;
            end
            else
            begin
                shift_reg <= {shift_reg[22:0], 1'b0};
            end
        end
        if (res_valid)
        begin
            out_duty_reg <= res_duty;
            out_last_reg <= res_last;
        end
    end

    assign slot.valid      = out_valid_reg;
    assign slot.duty       = out_duty_reg;
    assign slot.frame_last = out_last_reg;

endmodule

@@ hw/rtl/rlcpe_colour_mem.sv @@
// colour store and frame snapshot memories with the snapshot copy sweep
`timescale 1ns / 1ps

module rlcpe_colour_mem #(
    parameter int unsigned LED_COUNT = 8,
    parameter int unsigned IDX_W     = 3
) (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        set_we,
    input  logic [IDX_W-1:0]            set_idx,
    input  logic [23:0]                 set_data,
    input  logic                        copy_start,
    input  logic [IDX_W-1:0]            snap_raddr,
    output logic [23:0]                 snap_rdata,
    output logic [23:0]                 copy_data,
    output rlcpe_pkg::copy_stat_t       copy_stat
);
    import rlcpe_pkg::*;

    localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(LED_COUNT - 1);

    logic [23:0]          store_mem [LED_COUNT];
    logic [23:0]          snap_mem  [LED_COUNT];
    logic [LED_COUNT-1:0] written_reg;

    logic                 rd_act_reg;
    logic [IDX_W-1:0]     rd_ptr_reg;
    logic                 wr_act_reg;
    logic [IDX_W-1:0]     wr_ptr_reg;
    logic [23:0]          store_rd_reg;
    logic                 store_ok_reg;
    logic [23:0]          snap_rd_reg;

    // store entries never written read as zero
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            written_reg  <= '0;
            store_ok_reg <= 1'b0;
            rd_act_reg   <= 1'b0;
            rd_ptr_reg   <= '0;
            wr_act_reg   <= 1'b0;
            wr_ptr_reg   <= '0;
        end
        else
        begin
            if (set_we)
            begin
                written_reg[set_idx] <= 1'b1;
            end
            store_ok_reg <= written_reg[rd_ptr_reg];
            wr_act_reg   <= rd_act_reg;
            wr_ptr_reg   <= rd_ptr_reg;
            if (copy_start)
            begin
                rd_act_reg <= 1'b1;
                rd_ptr_reg <= '0;
            end
            else if (rd_act_reg)
            begin
                if (rd_ptr_reg == LAST_IDX)
                begin
                    rd_act_reg <= 1'b0;
                end
                else
                begin
                    rd_ptr_reg <= rd_ptr_reg + 1'b1;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (set_we)
        begin
            store_mem[set_idx] <= set_data;
        end
        store_rd_reg <= store_mem[rd_ptr_reg];
    end

    always_ff @(posedge clk)
    begin
        if (wr_act_reg)
        begin
            snap_mem[wr_ptr_reg] <= copy_data;
        end
        snap_rd_reg <= snap_mem[snap_raddr];
    end

    assign copy_data       = store_ok_reg ? store_rd_reg : 24'd0;
    assign snap_rdata      = snap_rd_reg;
    assign copy_stat.first = wr_act_reg && (wr_ptr_reg == '0);
    assign copy_stat.done  = wr_act_reg && (wr_ptr_reg == LAST_IDX);

endmodule
